>>> rtl/spn_pkg.sv
package spn_pkg;

  localparam int NUM_STAGES = 4;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
  };

  localparam logic [3:0] SBOX_INV [16] = '{
    4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
    4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
  };

  localparam logic [3:0] BIT_MAP [16] = '{
    4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
  };

  typedef struct packed {
    logic dir;
    logic first_round;
    logic last_round;
  } round_ctl_t;

  function automatic logic [15:0] sub_nibbles(input logic [15:0] x, input logic inv);
    logic [15:0] y;
    y = '0;
    for (int n = 0; n < 4; n++) begin
      if (inv) begin
        y[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
      end else begin
        y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
      end
    end
    return y;
  endfunction

  function automatic logic [15:0] transpose(input logic [15:0] x);
    logic [15:0] y;
    y = '0;
    for (int j = 0; j < 16; j++) begin
      y[15-j] = x[4'd15 - BIT_MAP[j]];
    end
    return y;
  endfunction

  // Round key r (1 to 5) starts 4*(r-1) bits below the top of the key.
  function automatic logic [15:0] key_slice(input logic [31:0] key, input logic [2:0] r);
    logic [15:0] k;
    case (r)
      3'd1: k = key[31:16];
      3'd2: k = key[27:12];
      3'd3: k = key[23:8];
      3'd4: k = key[19:4];
      default: k = key[15:0];
    endcase
    return k;
  endfunction

endpackage

>>> rtl/spn_round.sv
module spn_round
  import spn_pkg::*;
(
  input  round_ctl_t  ctl,
  input  logic [15:0] data_in,
  input  logic [15:0] key_a,
  input  logic [15:0] key_b,
  output logic [15:0] data_out
);

  logic [15:0] enc_mix;
  logic [15:0] enc_sub;
  logic [15:0] enc_res;
  logic [15:0] dec_pre;
  logic [15:0] dec_res;

  always_comb begin
    enc_mix = data_in ^ key_a;
    enc_sub = sub_nibbles(enc_mix, 1'b0);
    enc_res = ctl.last_round ? (enc_sub ^ key_b) : transpose(enc_sub);
    dec_pre = ctl.first_round ? (data_in ^ key_a) : transpose(data_in);
    dec_res = sub_nibbles(dec_pre, 1'b1) ^ key_b;
    data_out = ctl.dir ? dec_res : enc_res;
  end

endmodule

>>> rtl/spn_block_cipher_16bit.sv
// Four-stage pipeline, one cipher round per stage.
// Throughput is one block per cycle while out_ready is high; an accepted request
// moves through data_r[0] to data_r[3] in order, and stalls only hold the pipe.
// Reset (rst_n low, synchronous) empties the pipeline and clears the key to zero.
module spn_block_cipher_16bit
  import spn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_data_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_block,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0]           cipher_key_r;
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] dir_r;
  logic [15:0]           data_r     [NUM_STAGES];
  logic [15:0]           round_nxt  [NUM_STAGES];
  logic [NUM_STAGES:0]   stage_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r <= '0;
    end else if (cfg_wr_en) begin
      cipher_key_r <= cfg_wr_data;
    end
  end

  assign stage_rdy[NUM_STAGES] = out_ready;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    logic        stage_dir;
    logic        stage_vin;
    logic [15:0] stage_din;
    logic [15:0] key_a;
    logic [15:0] key_b;
    round_ctl_t  ctl;

    if (i == 0) begin : g_first
      assign stage_dir = in_req_type;
      assign stage_vin = in_valid;
      assign stage_din = in_data_block;
    end else begin : g_rest
      assign stage_dir = dir_r[i-1];
      assign stage_vin = valid_r[i-1];
      assign stage_din = data_r[i-1];
    end

    assign stage_rdy[i]    = !valid_r[i] || stage_rdy[i+1];
    assign ctl.dir         = stage_dir;
    assign ctl.first_round = (i == 0);
    assign ctl.last_round  = (i == NUM_STAGES - 1);
    assign key_a = stage_dir ? key_slice(cipher_key_r, 3'd5)
                             : key_slice(cipher_key_r, 3'(i + 1));
    assign key_b = stage_dir ? key_slice(cipher_key_r, 3'(NUM_STAGES - i))
                             : key_slice(cipher_key_r, 3'd5);

    spn_round u_round (
      .ctl      (ctl),
      .data_in  (stage_din),
      .key_a    (key_a),
      .key_b    (key_b),
      .data_out (round_nxt[i])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (stage_rdy[i]) begin
        valid_r[i] <= stage_vin;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_rdy[i] && stage_vin) begin
        dir_r[i]  <= stage_dir;
        data_r[i] <= round_nxt[i];
      end
    end
  end

  assign in_ready         = stage_rdy[0];
  assign out_valid        = valid_r[NUM_STAGES-1];
  assign out_result_block = data_r[NUM_STAGES-1];

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_backpressure_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&valid_r) && !out_ready)
    else $error("input stalled while the pipeline has room");

  a_mid_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[1] && !stage_rdy[2] |=> valid_r[1] && $stable(data_r[1]) && $stable(dir_r[1]))
    else $error("stalled stage lost or changed its data");
`endif

endmodule
